/* hdl/idsp_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, payload types and register codes of the diffusion stencil pass.
package idsp_pkg;

   // Geometry defaults for the line buffers
   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_HEIGHT_DEF = 1024;

   // Register reset values and legal bounds
   localparam int MIN_DIM     = 3;
   localparam int DIM_RESET   = 1024;
   localparam int KAPPA_RESET = 3277;
   localparam int KAPPA_MAX   = 16384;

   // Field widths
   localparam int CFG_DIM_W   = 11;
   localparam int KAPPA_W     = 15;
   localparam int CSR_DATA_W  = 15;
   localparam int CSR_INDEX_W = 2;
   localparam int PIX_W       = 16;
   localparam int IDX_W       = 10;

   // Datapath widths: 4-neighbor laplacian, gain product, accumulator
   localparam int LAP_W      = 19;
   localparam int GAIN_W     = 16;
   localparam int PROD_W     = 35;
   localparam int ACC_W      = 36;
   localparam int FRAC_W     = 16;
   localparam int ROUND_HALF = 32768;

   typedef logic [PIX_W-1:0] pixel_type;

   // Register indexes on the csr port
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1,
      CSR_KAPPA_GAIN   = 2'd2
   } csr_index_type;

   // Per-pixel bookkeeping that rides along with the data
   typedef struct packed {
      logic             has_a;     // stencil/border result for the row above
      logic             has_b;     // last-row copy of the incoming pixel
      logic             interior;  // row above is an interior position
      logic             last_col;
      logic [IDX_W-1:0] row_a;
      logic [IDX_W-1:0] row_b;
      logic [IDX_W-1:0] col;
   } tag_type;

   // 5-point window around the center pixel of the row above
   typedef struct packed {
      tag_type   tag;
      pixel_type centre;
      pixel_type up;
      pixel_type left;
      pixel_type right;
      pixel_type down;
   } window_type;

   // Gain-scaled laplacian heading for rounding and saturation
   typedef struct packed {
      tag_type                   tag;
      pixel_type                 centre;
      pixel_type                 down;
      logic signed [PROD_W-1:0]  prod;
   } product_type;

endpackage

/* hdl/idsp_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the pixel input and the result output.
interface idsp_req_if;
   logic                valid;
   logic                ready;
   idsp_pkg::pixel_type pixel_in;

   modport source (output valid, output pixel_in, input ready);
   modport sink   (input valid, input pixel_in, output ready);
endinterface

interface idsp_rsp_if;
   logic                             valid;
   logic                             ready;
   idsp_pkg::pixel_type              pixel_out;
   logic [idsp_pkg::IDX_W-1:0]       out_row;
   logic [idsp_pkg::IDX_W-1:0]       out_col;
   logic                             end_of_image;

   modport source (output valid, output pixel_out, output out_row, output out_col,
                   output end_of_image, input ready);
   modport sink   (input valid, input pixel_out, input out_row, input out_col,
                   input end_of_image, output ready);
endinterface

/* hdl/idsp_window.sv */
`timescale 1ns / 1ps
// Raster counters, two line buffers and the window fetch stage.
module idsp_window #(
   parameter int MAX_WIDTH  = idsp_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = idsp_pkg::MAX_HEIGHT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   idsp_req_if.sink                          req_chan,
   input  logic [$clog2(MAX_WIDTH+1)-1:0]    w_eff,
   input  logic [$clog2(MAX_HEIGHT+1)-1:0]   h_eff,
   output idsp_pkg::window_type              win,
   output logic                              win_valid,
   input  logic                              win_ready
);

   localparam int CB  = $clog2(MAX_WIDTH);
   localparam int WW  = $clog2(MAX_WIDTH+1);
   localparam int RB  = $clog2(MAX_HEIGHT);
   localparam int OIW = idsp_pkg::IDX_W;

   logic [CB-1:0]         col_ff, col_in, c_cur, addr_right, s1_col_ff;
   logic [RB-1:0]         row_ff, row_in, r_cur;
   logic [RB:0]           row_inc;
   logic                  col_wrap, last_col, last_row;
   logic                  accept, s1_ready, handoff;
   logic                  v1_ff, v1_in;
   idsp_pkg::tag_type     tag_in, tag_ff;
   idsp_pkg::pixel_type   cur_ff, mid_ff, up_ff, right_ff, left_ff, left_in;

   // line buffers: row r-1 and row r-2
   idsp_pkg::pixel_type   prev_mem  [MAX_WIDTH];
   idsp_pkg::pixel_type   older_mem [MAX_WIDTH];

   // stage handshake
   always_comb begin
      s1_ready       = !v1_ff || win_ready;
      req_chan.ready = s1_ready;
      accept         = req_chan.valid && s1_ready;
      handoff        = v1_ff && win_ready;
      v1_in          = s1_ready ? req_chan.valid : v1_ff;
      left_in        = handoff ? mid_ff : left_ff;
   end

   // position of the incoming pixel, wrapping stale counters first
   always_comb begin
      col_wrap   = (WW'(col_ff) >= w_eff);
      c_cur      = col_wrap ? '0 : col_ff;
      row_inc    = (RB+1)'(row_ff) + (RB+1)'(col_wrap);
      r_cur      = (row_inc >= (RB+1)'(h_eff)) ? '0 : row_inc[RB-1:0];
      last_col   = (WW'(c_cur) == w_eff - WW'(1));
      last_row   = ((RB+1)'(r_cur) == (RB+1)'(h_eff) - (RB+1)'(1));
      addr_right = last_col ? c_cur : c_cur + CB'(1);
   end

   // counters after this pixel
   always_comb begin
      if (last_col) begin
         col_in = '0;
         row_in = last_row ? '0 : r_cur + RB'(1);
      end else begin
         col_in = c_cur + CB'(1);
         row_in = r_cur;
      end
   end

   // result bookkeeping for this pixel
   always_comb begin
      tag_in.has_a    = (r_cur != '0);
      tag_in.has_b    = last_row;
      tag_in.interior = (r_cur > RB'(1)) && (c_cur != '0) && !last_col;
      tag_in.last_col = last_col;
      tag_in.row_a    = OIW'(r_cur - RB'(1));
      tag_in.row_b    = OIW'(r_cur);
      tag_in.col      = OIW'(c_cur);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         v1_ff  <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
      end
   end

   // buffer reads and writes; row r-2 is refreshed from the stage register
   always_ff @(posedge clock) begin
      if (accept) begin
         mid_ff            <= prev_mem[c_cur];
         right_ff          <= prev_mem[addr_right];
         up_ff             <= older_mem[c_cur];
         prev_mem[c_cur]   <= req_chan.pixel_in;
         cur_ff            <= req_chan.pixel_in;
         tag_ff            <= tag_in;
         s1_col_ff         <= c_cur;
      end
      if (v1_ff) begin
         older_mem[s1_col_ff] <= mid_ff;
      end
      left_ff <= left_in;
   end

   // left neighbor is the center of the pixel that went just before
   always_comb begin
      win.tag    = tag_ff;
      win.centre = mid_ff;
      win.up     = up_ff;
      win.left   = left_ff;
      win.right  = right_ff;
      win.down   = cur_ff;
      win_valid  = v1_ff;
   end

`ifndef SYNTHESIS
   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      (accept && last_col && last_row) |=> (col_ff == '0 && row_ff == '0))
      else $error("raster counters did not return to origin after the last pixel");
   a_interior_row: assert property (@(posedge clock) disable iff (reset)
      v1_ff |-> (!tag_ff.interior || tag_ff.has_a))
      else $error("interior position flagged without a row above");
`endif

endmodule

/* hdl/idsp_diffuse.sv */
`timescale 1ns / 1ps
// Laplacian and gain multiply stages of the stencil datapath.
module idsp_diffuse (
   input  logic                                clock,
   input  logic                                reset,
   input  idsp_pkg::window_type                win,
   input  logic                                win_valid,
   output logic                                win_ready,
   input  logic [idsp_pkg::KAPPA_W-1:0]        gain,
   output idsp_pkg::product_type               prd,
   output logic                                prd_valid,
   input  logic                                prd_ready
);

   localparam int LW = idsp_pkg::LAP_W;
   localparam int PW = idsp_pkg::PROD_W;
   localparam int GW = idsp_pkg::GAIN_W;

   logic                         ready2, ready3;
   logic                         v2_ff, v2_in, v3_ff, v3_in;
   logic [LW-2:0]                sum_in;
   logic signed [LW-1:0]         lap_in, lap2_ff;
   logic signed [GW-1:0]         gain_s;
   logic signed [PW-1:0]         prod_in, prod3_ff;
   idsp_pkg::tag_type            tag2_ff, tag3_ff;
   idsp_pkg::pixel_type          centre2_ff, down2_ff, centre3_ff, down3_ff;

   // stage handshake
   always_comb begin
      ready3    = !v3_ff || prd_ready;
      ready2    = !v2_ff || ready3;
      win_ready = ready2;
      v2_in     = ready2 ? win_valid : v2_ff;
      v3_in     = ready3 ? v2_ff : v3_ff;
   end

   // laplacian: four neighbors minus four times the center
   always_comb begin
      sum_in = (LW-1)'(win.up) + (LW-1)'(win.left) + (LW-1)'(win.right)
             + (LW-1)'(win.down);
      lap_in = $signed({1'b0, sum_in}) - $signed({1'b0, win.centre, 2'b00});
   end

   // gain times laplacian
   always_comb begin
      gain_s  = $signed({1'b0, gain});
      prod_in = PW'(lap2_ff) * PW'(gain_s);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      if (ready2) begin
         tag2_ff    <= win.tag;
         centre2_ff <= win.centre;
         down2_ff   <= win.down;
         lap2_ff    <= lap_in;
      end
      if (ready3) begin
         tag3_ff    <= tag2_ff;
         centre3_ff <= centre2_ff;
         down3_ff   <= down2_ff;
         prod3_ff   <= prod_in;
      end
   end

   always_comb begin
      prd.tag    = tag3_ff;
      prd.centre = centre3_ff;
      prd.down   = down3_ff;
      prd.prod   = prod3_ff;
      prd_valid  = v3_ff;
   end

endmodule

/* hdl/idsp_out_buf.sv */
`timescale 1ns / 1ps
// Rounding, saturation and the two-entry result register feeding the output channel.
module idsp_out_buf (
   input  logic                     clock,
   input  logic                     reset,
   input  idsp_pkg::product_type    prd,
   input  logic                     prd_valid,
   output logic                     prd_ready,
   idsp_rsp_if.source               rsp_chan
);

   localparam int AW  = idsp_pkg::ACC_W;
   localparam int FW  = idsp_pkg::FRAC_W;
   localparam int PXW = idsp_pkg::PIX_W;
   localparam int OIW = idsp_pkg::IDX_W;

   logic signed [AW-1:0]    acc;
   idsp_pkg::pixel_type     diff, a_pix_in, a_pix_ff, b_pix_ff;
   logic                    a_pend_ff, a_pend_in, b_pend_ff, b_pend_in;
   logic                    load, take;
   logic [OIW-1:0]          a_row_ff, b_row_ff, col_ff;
   logic                    eoi_ff;

   // u*2^16 + kappa*lap + half, then floor and clamp to the pixel range
   always_comb begin
      acc = AW'($signed({1'b0, prd.centre, FW'(0)})) + AW'(prd.prod)
          + AW'(idsp_pkg::ROUND_HALF);
      if (acc[AW-1]) begin
         diff = '0;
      end else if (|acc[AW-2:FW+PXW]) begin
         diff = '1;
      end else begin
         diff = acc[FW+PXW-1:FW];
      end
      a_pix_in = prd.tag.interior ? diff : prd.centre;
   end

   // new pair enters if the register is empty or a lone pending entry drains this cycle
   always_comb begin
      take      = rsp_chan.valid && rsp_chan.ready;
      prd_ready = (!a_pend_ff && !b_pend_ff) || (rsp_chan.ready && (a_pend_ff ^ b_pend_ff));
      load      = prd_valid && prd_ready;
      if (load) begin
         a_pend_in = prd.tag.has_a;
         b_pend_in = prd.tag.has_b;
      end else if (take && a_pend_ff) begin
         a_pend_in = 1'b0;
         b_pend_in = b_pend_ff;
      end else if (take) begin
         a_pend_in = 1'b0;
         b_pend_in = 1'b0;
      end else begin
         a_pend_in = a_pend_ff;
         b_pend_in = b_pend_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_pend_ff <= 1'b0;
         b_pend_ff <= 1'b0;
      end else begin
         a_pend_ff <= a_pend_in;
         b_pend_ff <= b_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         a_pix_ff <= a_pix_in;
         b_pix_ff <= prd.down;
         a_row_ff <= prd.tag.row_a;
         b_row_ff <= prd.tag.row_b;
         col_ff   <= prd.tag.col;
         eoi_ff   <= prd.tag.last_col;
      end
   end

   // row-above result goes out before the last-row copy
   always_comb begin
      rsp_chan.valid        = a_pend_ff || b_pend_ff;
      rsp_chan.pixel_out    = a_pend_ff ? a_pix_ff : b_pix_ff;
      rsp_chan.out_row      = a_pend_ff ? a_row_ff : b_row_ff;
      rsp_chan.out_col      = col_ff;
      rsp_chan.end_of_image = a_pend_ff ? 1'b0 : eoi_ff;
   end

`ifndef SYNTHESIS
   a_pair_rows: assert property (@(posedge clock) disable iff (reset)
      (a_pend_ff && b_pend_ff) |-> (b_row_ff == a_row_ff + OIW'(1)))
      else $error("paired results are not on adjacent rows");
   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      (a_pend_ff && b_pend_ff && rsp_chan.ready) |=> (b_pend_ff && !a_pend_ff))
      else $error("last-row copy lost or sent ahead of the row above");
`endif

endmodule

/* hdl/isotropic_diffusion_stencil_pass.sv */
`timescale 1ns / 1ps
// Top level of the isotropic diffusion stencil pass.
// Pixels (unsigned Q8.8) enter on req_chan in row-major order, one transaction each.
// Results leave on rsp_chan with their row, column and an end-of-image flag; the
// results for row r are produced while row r+1 streams in, and during the last row
// each pixel also yields its own copy right after the result for the pixel above.
// Interior pixels get u + kappa*(4-neighbor sum - 4u), rounded and saturated;
// border rows and columns pass through unchanged.
// Each result passes the fetch, laplacian, product and result registers in turn.
// One pixel per clock unless stalled; in the last row the output port sets the pace
// at two results per pixel. The four-stage pipeline (buffer fetch, laplacian, gain
// multiply, round/saturate into the result register) lets a pixel enter every cycle.
// Width, height and kappa are written on the csr port while the block is idle.
// Reset clears the raster counters and pipeline valids and restores the register
// defaults; line buffer contents are not cleared and are rebuilt by the first row.
// When rsp_chan stalls, the result register and pipeline stages hold and input ready
// falls only once every stage is occupied; nothing is dropped or repeated.
module isotropic_diffusion_stencil_pass #(
   parameter int MAX_WIDTH  = idsp_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = idsp_pkg::MAX_HEIGHT_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   idsp_req_if.sink                              req_chan,
   idsp_rsp_if.source                            rsp_chan,
   input  logic                                  csr_we,
   input  logic [idsp_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [idsp_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int WW = $clog2(MAX_WIDTH+1);
   localparam int HW = $clog2(MAX_HEIGHT+1);
   localparam int KW = idsp_pkg::KAPPA_W;
   localparam int DW = idsp_pkg::CFG_DIM_W;
   localparam int W_INIT = (idsp_pkg::DIM_RESET > MAX_WIDTH) ? MAX_WIDTH : idsp_pkg::DIM_RESET;
   localparam int H_INIT = (idsp_pkg::DIM_RESET > MAX_HEIGHT) ? MAX_HEIGHT
                                                               : idsp_pkg::DIM_RESET;

   logic [WW-1:0]          w_eff_ff, w_eff_in, w_clamp;
   logic [HW-1:0]          h_eff_ff, h_eff_in, h_clamp;
   logic [KW-1:0]          gain_ff, gain_in, gain_clamp;
   logic [DW-1:0]          dim_raw;
   idsp_pkg::window_type   win;
   logic                   win_valid, win_ready;
   idsp_pkg::product_type  prd;
   logic                   prd_valid, prd_ready;

   // registers hold clamped values so the datapath sees only legal geometry
   always_comb begin
      dim_raw = csr_wdata[DW-1:0];
      if (int'(dim_raw) < idsp_pkg::MIN_DIM) begin
         w_clamp = WW'(idsp_pkg::MIN_DIM);
         h_clamp = HW'(idsp_pkg::MIN_DIM);
      end else begin
         w_clamp = (int'(dim_raw) > MAX_WIDTH)  ? WW'(MAX_WIDTH)  : WW'(dim_raw);
         h_clamp = (int'(dim_raw) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(dim_raw);
      end
      gain_clamp = (int'(csr_wdata[KW-1:0]) > idsp_pkg::KAPPA_MAX)
                 ? KW'(idsp_pkg::KAPPA_MAX) : csr_wdata[KW-1:0];
   end

   // register write decode; unknown indexes are ignored
   always_comb begin
      w_eff_in = w_eff_ff;
      h_eff_in = h_eff_ff;
      gain_in  = gain_ff;
      if (csr_we && csr_index == idsp_pkg::CSR_IMAGE_WIDTH) begin
         w_eff_in = w_clamp;
      end else if (csr_we && csr_index == idsp_pkg::CSR_IMAGE_HEIGHT) begin
         h_eff_in = h_clamp;
      end else if (csr_we && csr_index == idsp_pkg::CSR_KAPPA_GAIN) begin
         gain_in = gain_clamp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_eff_ff <= WW'(W_INIT);
         h_eff_ff <= HW'(H_INIT);
         gain_ff  <= KW'(idsp_pkg::KAPPA_RESET);
      end else begin
         w_eff_ff <= w_eff_in;
         h_eff_ff <= h_eff_in;
         gain_ff  <= gain_in;
      end
   end

   idsp_window #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_window (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .w_eff     (w_eff_ff),
      .h_eff     (h_eff_ff),
      .win       (win),
      .win_valid (win_valid),
      .win_ready (win_ready)
   );

   idsp_diffuse u_diffuse (
      .clock     (clock),
      .reset     (reset),
      .win       (win),
      .win_valid (win_valid),
      .win_ready (win_ready),
      .gain      (gain_ff),
      .prd       (prd),
      .prd_valid (prd_valid),
      .prd_ready (prd_ready)
   );

   idsp_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .prd       (prd),
      .prd_valid (prd_valid),
      .prd_ready (prd_ready),
      .rsp_chan  (rsp_chan)
   );

endmodule

/* bench/isotropic_diffusion_stencil_pass_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for the diffusion stencil pass: streamed images, predicted results.
module isotropic_diffusion_stencil_pass_tb;

   localparam int CLOCK_HALF    = 4;
   localparam int RESET_CYCLES  = 12;
   localparam int SETTLE_CYCLES = 8;
   localparam int LIMIT_CYCLES  = 60000;
   localparam int IDLE_PERCENT  = 35;
   localparam int RANDOM_ITEMS  = 900;

   // How the pixel values of a streamed image are picked
   typedef enum int {
      PIX_RANDOM,
      PIX_EXTREME,
      PIX_SMOOTH,
      PIX_MIXED
   } pixel_mode_type;

   // One emitted pixel with its position
   typedef struct packed {
      idsp_pkg::pixel_type        pixel;
      logic [idsp_pkg::IDX_W-1:0] row;
      logic [idsp_pkg::IDX_W-1:0] col;
      logic                       eoi;
   } stencil_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                             csr_we    = 1'b0;
   logic [idsp_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [idsp_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   idsp_req_if req_chan ();
   idsp_rsp_if rsp_chan ();

   isotropic_diffusion_stencil_pass DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Pixels waiting to be sent, pixels due from the block
   idsp_pkg::pixel_type raster_feed [$];
   stencil_result_type  due_pixels [$];
   int                  mismatch_count = 0;
   int                  cycle_count = 0;
   logic                feed_steady  = 1'b0;
   logic                drain_steady = 1'b0;

   // Predictor copy of the registers and raster state
   logic [idsp_pkg::CFG_DIM_W-1:0] cfg_width  = idsp_pkg::CFG_DIM_W'(idsp_pkg::DIM_RESET);
   logic [idsp_pkg::CFG_DIM_W-1:0] cfg_height = idsp_pkg::CFG_DIM_W'(idsp_pkg::DIM_RESET);
   logic [idsp_pkg::KAPPA_W-1:0]   cfg_kappa  = idsp_pkg::KAPPA_W'(idsp_pkg::KAPPA_RESET);
   idsp_pkg::pixel_type            above_line [idsp_pkg::MAX_WIDTH_DEF];
   idsp_pkg::pixel_type            older_line [idsp_pkg::MAX_WIDTH_DEF];
   int unsigned                    row_pos = 0;
   int unsigned                    col_pos = 0;
   stencil_result_type             head_result;

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
      if (v < idsp_pkg::MIN_DIM) return idsp_pkg::MIN_DIM;
      if (v > hi) return hi;
      return v;
   endfunction

   // u + kappa * laplacian, rounded half up, saturated to the pixel range
   function automatic idsp_pkg::pixel_type stencil_value(input int unsigned centre, up, left,
                                                         right, down, gain);
      longint lap;
      longint acc;
      longint q;
      lap = longint'(up) + longint'(left) + longint'(right) + longint'(down)
            - 4 * longint'(centre);
      acc = (longint'(centre) << idsp_pkg::FRAC_W) + lap * longint'(gain)
            + idsp_pkg::ROUND_HALF;
      if (acc < 0) return '0;
      q = acc >>> idsp_pkg::FRAC_W;
      if (q > 65535) return '1;
      return idsp_pkg::pixel_type'(q);
   endfunction

   // Advance the raster by one pixel and queue the results it releases
   task automatic diffuse_step(input idsp_pkg::pixel_type cur);
      int unsigned         w;
      int unsigned         h;
      int unsigned         gain;
      int unsigned         r;
      int unsigned         c;
      idsp_pkg::pixel_type mid;
      stencil_result_type  res;
      w = clamp_dim(cfg_width, idsp_pkg::MAX_WIDTH_DEF);
      h = clamp_dim(cfg_height, idsp_pkg::MAX_HEIGHT_DEF);
      gain = (cfg_kappa > idsp_pkg::KAPPA_MAX) ? idsp_pkg::KAPPA_MAX : cfg_kappa;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
      end
      if (row_pos >= h) row_pos = 0;
      r = row_pos;
      c = col_pos;
      mid = above_line[c];
      // result for the row above: border copy or stencil
      if (r >= 1) begin
         if (r == 1 || c == 0 || c == w - 1) begin
            res.pixel = mid;
         end else begin
            res.pixel = stencil_value(mid, older_line[c], older_line[c-1], above_line[c+1],
                                      cur, gain);
         end
         res.row = idsp_pkg::IDX_W'(r - 1);
         res.col = idsp_pkg::IDX_W'(c);
         res.eoi = 1'b0;
         due_pixels.push_back(res);
      end
      // last row also copies itself out
      if (r == h - 1) begin
         res.pixel = cur;
         res.row   = idsp_pkg::IDX_W'(r);
         res.col   = idsp_pkg::IDX_W'(c);
         res.eoi   = (c == w - 1);
         due_pixels.push_back(res);
      end
      older_line[c] = mid;
      above_line[c] = cur;
      col_pos = c + 1;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos = r + 1;
         if (row_pos >= h) row_pos = 0;
      end
   endtask

   // Input driver: holds a pixel until taken, idles at random between transactions
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) diffuse_step(raster_feed.pop_front());
         if (!req_chan.valid || req_chan.ready) begin
            if (raster_feed.size() > 0 &&
                (feed_steady || $urandom_range(99) >= IDLE_PERCENT)) begin
               req_chan.valid    <= 1'b1;
               req_chan.pixel_in <= raster_feed[0];
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   task automatic compare_field(input string name, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // Result monitor: checks each transaction against the oldest due pixel
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (due_pixels.size() == 0) begin
               $display({"%0t: unexpected result, expected none, ",
                         "actual pixel %0d row %0d col %0d eoi %0b"},
                        $time, rsp_chan.pixel_out, rsp_chan.out_row, rsp_chan.out_col,
                        rsp_chan.end_of_image);
               mismatch_count++;
            end else begin
               head_result = due_pixels.pop_front();
               compare_field("pixel_out", head_result.pixel, rsp_chan.pixel_out);
               compare_field("out_row", head_result.row, rsp_chan.out_row);
               compare_field("out_col", head_result.col, rsp_chan.out_col);
               compare_field("end_of_image", head_result.eoi, rsp_chan.end_of_image);
            end
         end
         rsp_chan.ready <= drain_steady || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   // Watchdog
   initial begin
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TEST FAILED");
      $finish;
   end

   task automatic write_csr(input idsp_pkg::csr_index_type idx, input int unsigned value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= idsp_pkg::CSR_DATA_W'(value);
      case (idx)
         idsp_pkg::CSR_IMAGE_WIDTH:  cfg_width  = idsp_pkg::CFG_DIM_W'(value);
         idsp_pkg::CSR_IMAGE_HEIGHT: cfg_height = idsp_pkg::CFG_DIM_W'(value);
         idsp_pkg::CSR_KAPPA_GAIN:   cfg_kappa  = idsp_pkg::KAPPA_W'(value);
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Block idle: nothing queued, nothing on the bus, nothing due, then a settle wait
   task automatic wait_drained();
      do @(negedge clock);
      while (raster_feed.size() != 0 || req_chan.valid || due_pixels.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic idsp_pkg::pixel_type make_pixel(input pixel_mode_type mode);
      pixel_mode_type pick;
      pick = (mode == PIX_MIXED) ? pixel_mode_type'($urandom_range(2)) : mode;
      case (pick)
         PIX_EXTREME: begin
            case ($urandom_range(3))
               0: return 16'h0000;
               1: return 16'hFFFF;
               2: return 16'h0001;
               default: return 16'hFFFE;
            endcase
         end
         PIX_SMOOTH: return 16'h6000 + idsp_pkg::pixel_type'($urandom_range(16'h0FFF));
         default:    return idsp_pkg::pixel_type'($urandom_range(16'hFFFF));
      endcase
   endfunction

   // Reprogram at an image boundary and queue whole images
   task automatic run_phase(input int unsigned width_val, input int unsigned height_val,
                            input int unsigned kappa_val, input int images,
                            input pixel_mode_type mode, input logic steady_in,
                            input logic steady_out);
      int unsigned count;
      wait_drained();
      write_csr(idsp_pkg::CSR_IMAGE_WIDTH, width_val);
      write_csr(idsp_pkg::CSR_IMAGE_HEIGHT, height_val);
      write_csr(idsp_pkg::CSR_KAPPA_GAIN, kappa_val);
      @(negedge clock);
      feed_steady  = steady_in;
      drain_steady = steady_out;
      count = clamp_dim(width_val, idsp_pkg::MAX_WIDTH_DEF)
              * clamp_dim(height_val, idsp_pkg::MAX_HEIGHT_DEF) * images;
      repeat (count) raster_feed.push_back(make_pixel(mode));
   endtask

   initial begin
      int unsigned random_items;
      int unsigned width_val;
      int unsigned height_val;
      int unsigned kappa_val;
      int          images;
      req_chan.valid    = 1'b0;
      req_chan.pixel_in = '0;
      rsp_chan.ready    = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed: 4x4 checkerboard of the extremes at the reset gain
      write_csr(idsp_pkg::CSR_IMAGE_WIDTH, 4);
      write_csr(idsp_pkg::CSR_IMAGE_HEIGHT, 4);
      @(negedge clock);
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            raster_feed.push_back(((r + c) % 2 == 1) ? 16'hFFFF : 16'h0000);
         end
      end

      // Directed: geometry below range and gain above range, all clamped
      run_phase(0, 1, 32767, 1, PIX_EXTREME, 1'b0, 1'b0);

      // Random small images over many settings
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         width_val  = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(3, 12);
         height_val = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(3, 6);
         case ($urandom_range(5))
            0:       kappa_val = 0;
            1:       kappa_val = idsp_pkg::KAPPA_MAX;
            2:       kappa_val = $urandom_range(idsp_pkg::KAPPA_MAX + 1, 32767);
            default: kappa_val = $urandom_range(idsp_pkg::KAPPA_MAX);
         endcase
         images = $urandom_range(1, 3);
         run_phase(width_val, height_val, kappa_val, images,
                   pixel_mode_type'($urandom_range(3)), $urandom_range(5) == 0,
                   $urandom_range(5) == 0);
         random_items += clamp_dim(width_val, idsp_pkg::MAX_WIDTH_DEF)
                         * clamp_dim(height_val, idsp_pkg::MAX_HEIGHT_DEF) * images;
      end

      // Wide image, no idling on either side
      run_phase(64, 5, $urandom_range(idsp_pkg::KAPPA_MAX), 1, PIX_MIXED, 1'b1, 1'b1);
      // Tall narrow image, full gain
      run_phase(3, 90, idsp_pkg::KAPPA_MAX, 1, PIX_MIXED, 1'b0, 1'b0);

      wait_drained();
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
